[design/rpn_pkg.sv]
// Shared types and constants for the RPN stack calculator.
package rpn_pkg;

    localparam int DATA_W = 32;

    // Command codes carried by an input word.
    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_POP     = 3'd5,
        CMD_INVALID = 3'd6
    } cmd_t;

    // Status codes carried by a result word.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_INVALID   = 3'd4,
        ST_HALTED    = 3'd5
    } status_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FINISH
    } state_t;

endpackage

[design/rpn_stack_mem.sv]
// Stack storage: one write port and one read port with registered read data.
module rpn_stack_mem #(
    parameter int STACK_DEPTH = 128,
    parameter int AW          = 7
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [rpn_pkg::DATA_W-1:0]  wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [rpn_pkg::DATA_W-1:0]  rdata
);

    logic [rpn_pkg::DATA_W-1:0] mem [STACK_DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/rpn_divider.sv]
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
module rpn_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rpn_pkg::DATA_W-1:0]  dividend,
    input  logic [rpn_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [rpn_pkg::DATA_W-1:0]  quotient
);

    localparam int W  = rpn_pkg::DATA_W;
    localparam int SW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [W:0]    rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic          neg_reg;

    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic [W:0]    rem_next;
    logic [W-1:0]  quo_next;

    // Operand magnitudes at start.
    assign mag_a = dividend[W-1] ? (~dividend + W'(1)) : dividend;
    assign mag_b = divisor[W-1]  ? (~divisor + W'(1))  : divisor;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh = {rem_reg[W-1:0], quo_reg[W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        if (!diff[W]) begin
            rem_next = diff;
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = rem_sh;
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    // Control: busy until the last step, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= mag_a;
            den_reg <= mag_b;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + W'(1)) : quo_reg;

endmodule

[design/rpn_stack_calculator.sv]
// Top level: RPN integer calculator with the stack held in a synchronous memory.
// Push, pop of the last entry and every error go from accept straight to FINISH;
// add, sub, mul and other pops pass READ first; div passes READ, then DIV.
// A new word is taken only once the last result is in the output register; the
// memory read of the second operand and the bit-serial divider set the pace.
// Reset (aresetn low, synchronous) empties the stack and clears the halted flag.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_command,
    input  logic signed [31:0]  s_operand_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic signed [31:0]  m_top_value,
    output logic [7:0]          m_stack_depth
);

    localparam int W  = rpn_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    rpn_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [W-1:0]    top_reg, top_next;
    logic            halted_reg, halted_next;
    logic [2:0]      cmd_reg, cmd_next;
    logic [2:0]      status_reg, status_next;
    logic            use_pop_reg, use_pop_next;
    logic [W-1:0]    popped_reg, popped_next;

    logic            m_valid_reg, m_valid_next;
    logic [2:0]      m_status_reg, m_status_next;
    logic [W-1:0]    m_top_reg, m_top_next;
    logic [7:0]      m_depth_reg, m_depth_next;

    logic            mem_we;
    logic            mem_re;
    logic [W-1:0]    mem_rdata;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   cnt_m2;
    logic [W-1:0]    product;
    logic [CW+7:0]   depth_ext;
    logic            div_start;
    logic            div_done;
    logic [W-1:0]    div_quot;

    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign product   = mem_rdata * top_reg;
    assign depth_ext = {8'd0, count_reg};

    // Entries below the top live in memory; the top itself is held in top_reg.
    rpn_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (cnt_m1[AW-1:0]),
        .wdata (top_reg),
        .re    (mem_re),
        .raddr (cnt_m2[AW-1:0]),
        .rdata (mem_rdata)
    );

    rpn_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mem_rdata),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_ready = (state_reg == rpn_pkg::S_IDLE);

    // Sequencer: decode at accept, read the second operand, compute, deliver.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        halted_next   = halted_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        use_pop_next  = use_pop_reg;
        popped_next   = popped_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        div_start     = 1'b0;

        case (state_reg)
            rpn_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_command;
                    status_next  = rpn_pkg::ST_OK;
                    use_pop_next = 1'b0;
                    state_next   = rpn_pkg::S_FINISH;
                    if (halted_reg) begin
                        status_next = rpn_pkg::ST_HALTED;
                    end else begin
                        case (s_command)
                            rpn_pkg::CMD_PUSH: begin
                                if (count_reg == CW'(STACK_DEPTH)) begin
                                    status_next = rpn_pkg::ST_OVERFLOW;
                                end else begin
                                    // Spill the old top into memory.
                                    mem_we     = (count_reg != '0);
                                    top_next   = s_operand_value;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                            rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
                                if (count_reg < CW'(2)) begin
                                    status_next = rpn_pkg::ST_UNDERFLOW;
                                end else if (s_command == rpn_pkg::CMD_DIV
                                             && top_reg == '0) begin
                                    status_next = rpn_pkg::ST_DIVZERO;
                                end else begin
                                    mem_re     = 1'b1;
                                    state_next = rpn_pkg::S_READ;
                                end
                            end
                            rpn_pkg::CMD_POP: begin
                                if (count_reg == '0) begin
                                    status_next = rpn_pkg::ST_UNDERFLOW;
                                end else begin
                                    use_pop_next = 1'b1;
                                    popped_next  = top_reg;
                                    count_next   = cnt_m1;
                                    // Refill the top register from memory.
                                    if (count_reg >= CW'(2)) begin
                                        mem_re     = 1'b1;
                                        state_next = rpn_pkg::S_READ;
                                    end
                                end
                            end
                            default: begin
                                status_next = rpn_pkg::ST_INVALID;
                                halted_next = 1'b1;
                            end
                        endcase
                    end
                end
            end

            rpn_pkg::S_READ: begin
                // The entry below the top is now on the read port.
                state_next = rpn_pkg::S_FINISH;
                if (cmd_reg != rpn_pkg::CMD_POP) begin
                    count_next = cnt_m1;
                end
                case (cmd_reg)
                    rpn_pkg::CMD_ADD: top_next = mem_rdata + top_reg;
                    rpn_pkg::CMD_SUB: top_next = mem_rdata - top_reg;
                    rpn_pkg::CMD_MUL: top_next = product;
                    rpn_pkg::CMD_DIV: begin
                        div_start  = 1'b1;
                        state_next = rpn_pkg::S_DIV;
                    end
                    default: top_next = mem_rdata;
                endcase
            end

            rpn_pkg::S_DIV: begin
                if (div_done) begin
                    top_next   = div_quot;
                    state_next = rpn_pkg::S_FINISH;
                end
            end

            rpn_pkg::S_FINISH: begin
                // Load the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    if (use_pop_reg) begin
                        m_top_next = popped_reg;
                    end else if (count_reg == '0) begin
                        m_top_next = '0;
                    end else begin
                        m_top_next = top_reg;
                    end
                    m_depth_next = depth_ext[7:0];
                    state_next   = rpn_pkg::S_IDLE;
                end
            end

            default: state_next = rpn_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpn_pkg::S_IDLE;
            count_reg   <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        use_pop_reg  <= use_pop_next;
        popped_reg   <= popped_next;
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_top_value   = m_top_reg;
    assign m_stack_depth = m_depth_reg;

endmodule

[design/rpn_checker.sv]
// Port-level checks for the RPN stack calculator, bound to the top level.
module rpn_checker #(
    parameter int STACK_DEPTH = 128
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_status,
    input logic signed [31:0] m_top_value,
    input logic [7:0]         m_stack_depth
);

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_top_value) && $stable(m_stack_depth))
        else $error("result word changed while stalled");

    // The reported depth never exceeds the stack size.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (STACK_DEPTH > 255) || (m_stack_depth <= STACK_DEPTH))
        else $error("stack depth beyond stack size");

    // Overflow is only reported on a full stack.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rpn_pkg::ST_OVERFLOW
            |-> m_stack_depth == 8'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

    // Underflow is only reported with fewer than two entries.
    a_udf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == rpn_pkg::ST_UNDERFLOW
            |-> (STACK_DEPTH > 255) || (m_stack_depth < 8'd2))
        else $error("underflow reported with enough operands");

    // A failed step on an empty stack shows a zero top.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stack_depth == 8'd0 && m_status != rpn_pkg::ST_OK
            |-> (STACK_DEPTH > 255) || (m_top_value == 32'sd0))
        else $error("nonzero top on an empty stack");

endmodule

bind rpn_stack_calculator rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rpn_checker (.*);

[tb/tb_rpn_stack_calculator.sv]
// Self-checking testbench for the RPN stack calculator: directed tokens, then random streams.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator;

    localparam int CLK_PERIOD      = 10;
    localparam int STACK_DEPTH     = 128;
    localparam int N_DIRECTED      = 21;
    localparam int N_RANDOM        = 1000;
    localparam int SEGMENT_LEN     = 40;
    localparam int MAX_IDLE        = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    // Code 7 is outside the command set and acts like an invalid token.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Mix of commands used by a random segment.
    localparam int MIX_BALANCED = 0;
    localparam int MIX_GROW     = 1;
    localparam int MIX_SHRINK   = 2;

    // One result word as the block should return it.
    typedef struct packed {
        rpn_pkg::status_t status;
        logic [31:0]      top;
        logic [7:0]       depth;
    } calc_result_t;

    // One directed token; typed rows carry a result written out by hand.
    typedef struct packed {
        rpn_pkg::cmd_t cmd;
        logic [31:0]   val;
        bit            typed;
        calc_result_t  want;
    } token_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_command;
    logic signed [31:0] s_operand_value;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic signed [31:0] m_top_value;
    logic [7:0]         m_stack_depth;

    // Shadow copy of the calculator state.
    logic [31:0] calc_stack [STACK_DEPTH];
    int          calc_count;
    bit          calc_halted;

    calc_result_t pending_results [$];
    int words_sent;
    int results_seen;
    int fail_count;
    int peak_depth;
    int status_hits [6];
    bit hold_off_req;

    // Directed tokens: empty-stack errors, wrap at the extremes, the most negative
    // value divided by minus one, divide by zero, truncating division, pop of empty.
    token_row_t directed_rows [N_DIRECTED] = '{
        '{rpn_pkg::CMD_POP,  32'h0,        1'b1, '{rpn_pkg::ST_UNDERFLOW, 32'h0,        8'd0}},
        '{rpn_pkg::CMD_ADD,  32'h0,        1'b1, '{rpn_pkg::ST_UNDERFLOW, 32'h0,        8'd0}},
        '{rpn_pkg::CMD_DIV,  32'hFFFFFFFF, 1'b1, '{rpn_pkg::ST_UNDERFLOW, 32'h0,        8'd0}},
        '{rpn_pkg::CMD_PUSH, 32'h7FFFFFFF, 1'b1, '{rpn_pkg::ST_OK,        32'h7FFFFFFF, 8'd1}},
        '{rpn_pkg::CMD_SUB,  32'h0,        1'b1, '{rpn_pkg::ST_UNDERFLOW, 32'h7FFFFFFF, 8'd1}},
        '{rpn_pkg::CMD_PUSH, 32'h1,        1'b1, '{rpn_pkg::ST_OK,        32'h1,        8'd2}},
        '{rpn_pkg::CMD_ADD,  32'h0,        1'b1, '{rpn_pkg::ST_OK,        32'h80000000, 8'd1}},
        '{rpn_pkg::CMD_PUSH, 32'hFFFFFFFF, 1'b1, '{rpn_pkg::ST_OK,        32'hFFFFFFFF, 8'd2}},
        '{rpn_pkg::CMD_DIV,  32'h0,        1'b1, '{rpn_pkg::ST_OK,        32'h80000000, 8'd1}},
        '{rpn_pkg::CMD_PUSH, 32'h0,        1'b1, '{rpn_pkg::ST_OK,        32'h0,        8'd2}},
        '{rpn_pkg::CMD_DIV,  32'h0,        1'b1, '{rpn_pkg::ST_DIVZERO,   32'h0,        8'd2}},
        '{rpn_pkg::CMD_MUL,  32'h5A5A5A5A, 1'b0, '0},
        '{rpn_pkg::CMD_PUSH, 32'hFFFFFFF9, 1'b0, '0},
        '{rpn_pkg::CMD_PUSH, 32'h2,        1'b0, '0},
        '{rpn_pkg::CMD_DIV,  32'h0,        1'b0, '0},
        '{rpn_pkg::CMD_PUSH, 32'h3,        1'b0, '0},
        '{rpn_pkg::CMD_MUL,  32'h0,        1'b0, '0},
        '{rpn_pkg::CMD_SUB,  32'h0,        1'b0, '0},
        '{rpn_pkg::CMD_PUSH, 32'h80000000, 1'b0, '0},
        '{rpn_pkg::CMD_SUB,  32'h0,        1'b0, '0},
        '{rpn_pkg::CMD_POP,  32'h0,        1'b0, '0}
    };

    rpn_stack_calculator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_operand_value(s_operand_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_top_value    (m_top_value),
        .m_stack_depth  (m_stack_depth)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Apply one token to the shadow stack and work out the word it should produce.
    task automatic eval_token(input logic [2:0] cmd, input logic [31:0] val,
                              output calc_result_t res);
        logic [31:0]      lhs;
        logic [31:0]      rhs;
        logic [31:0]      mag_l;
        logic [31:0]      mag_r;
        logic [31:0]      acc;
        logic [31:0]      shown;
        bit               from_pop;
        rpn_pkg::status_t st;
        st       = rpn_pkg::ST_OK;
        acc      = '0;
        shown    = '0;
        from_pop = 1'b0;
        if (calc_halted) begin
            st = rpn_pkg::ST_HALTED;
        end else begin
            case (cmd)
                rpn_pkg::CMD_PUSH: begin
                    if (calc_count >= STACK_DEPTH) begin
                        st = rpn_pkg::ST_OVERFLOW;
                    end else begin
                        calc_stack[calc_count] = val;
                        calc_count++;
                    end
                end
                rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
                    if (calc_count < 2) begin
                        st = rpn_pkg::ST_UNDERFLOW;
                    end else begin
                        // The entry below the top is the left operand.
                        rhs = calc_stack[calc_count - 1];
                        lhs = calc_stack[calc_count - 2];
                        case (cmd)
                            rpn_pkg::CMD_ADD: acc = lhs + rhs;
                            rpn_pkg::CMD_SUB: acc = lhs - rhs;
                            rpn_pkg::CMD_MUL: acc = lhs * rhs;
                            default: begin
                                if (rhs == '0) begin
                                    st = rpn_pkg::ST_DIVZERO;
                                end else begin
                                    // Divide magnitudes, then restore the sign.
                                    mag_l = lhs[31] ? -lhs : lhs;
                                    mag_r = rhs[31] ? -rhs : rhs;
                                    acc   = mag_l / mag_r;
                                    if (lhs[31] ^ rhs[31]) begin
                                        acc = -acc;
                                    end
                                end
                            end
                        endcase
                        if (st == rpn_pkg::ST_OK) begin
                            calc_count--;
                            calc_stack[calc_count - 1] = acc;
                        end
                    end
                end
                rpn_pkg::CMD_POP: begin
                    if (calc_count == 0) begin
                        st = rpn_pkg::ST_UNDERFLOW;
                    end else begin
                        calc_count--;
                        shown    = calc_stack[calc_count];
                        from_pop = 1'b1;
                    end
                end
                default: begin
                    st          = rpn_pkg::ST_INVALID;
                    calc_halted = 1'b1;
                end
            endcase
        end
        if (!from_pop && calc_count > 0) begin
            shown = calc_stack[calc_count - 1];
        end
        if (calc_count > peak_depth) begin
            peak_depth = calc_count;
        end
        status_hits[int'(st)]++;
        res.status = st;
        res.top    = shown;
        res.depth  = calc_count[7:0];
    endtask

    // Offer one word after a random gap, or none in burst phases, and record its expected result once taken.
    task automatic send_token(input logic [2:0] cmd, input logic [31:0] val,
                              input bit typed, input calc_result_t typed_res);
        int           gap;
        calc_result_t res;
        gap = (((words_sent / 64) % 3) == 2) ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_operand_value <= val;
        do @(posedge aclk); while (!(s_valid && s_ready));
        eval_token(cmd, val, res);
        pending_results.push_back(typed ? typed_res : res);
        words_sent++;
    endtask

    // Operands lean toward zero, one, minus one and the extremes.
    function automatic logic [31:0] pick_value();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 32'h0;
            1:       return 32'h1;
            2:       return 32'hFFFFFFFF;
            3:       return 32'h80000000;
            4:       return 32'h7FFFFFFF;
            5, 6:    return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_command(input int mix);
        int push_pct;
        int pick;
        case (mix)
            MIX_GROW:   push_pct = 80;
            MIX_SHRINK: push_pct = 15;
            default:    push_pct = 45;
        endcase
        if ($urandom_range(0, 99) < push_pct) begin
            return rpn_pkg::CMD_PUSH;
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    return rpn_pkg::CMD_ADD;
            2, 3:    return rpn_pkg::CMD_SUB;
            4, 5:    return rpn_pkg::CMD_MUL;
            6, 7:    return rpn_pkg::CMD_DIV;
            default: return rpn_pkg::CMD_POP;
        endcase
    endfunction

    task automatic send_random(input logic [2:0] cmd);
        send_token(cmd, (cmd == rpn_pkg::CMD_PUSH) ? pick_value() : $urandom(), 1'b0, '0);
    endtask

    // Report a failure; only the first few are printed in full.
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // Result receiver: random stalls, bursts without stalls, and one long hold-off.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = HOLD_OFF_CYCLES;
            end else begin
                stall = (((results_seen / 50) % 3) == 1) ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge aclk) begin : result_check
        calc_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected word: status %0d top %h depth %0d",
                                       m_status, m_top_value, m_stack_depth));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_top_value !== want.top ||
                    m_stack_depth !== want.depth) begin
                    note_failure($sformatf(
                        "word %0d: expected status %0d top %h depth %0d, got %0d %h %0d",
                        results_seen, want.status, want.top, want.depth,
                        m_status, m_top_value, m_stack_depth));
                end
            end
        end
    end

    // Abort when neither channel moves a word for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int mix;
        calc_count   = 0;
        calc_halted  = 1'b0;
        words_sent   = 0;
        results_seen = 0;
        fail_count   = 0;
        peak_depth   = 0;
        hold_off_req = 1'b0;
        mix          = MIX_BALANCED;
        foreach (status_hits[k]) status_hits[k] = 0;

        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_command       <= rpn_pkg::CMD_PUSH;
        s_operand_value <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed tokens.
        foreach (directed_rows[i]) begin
            send_token(directed_rows[i].cmd, directed_rows[i].val,
                       directed_rows[i].typed, directed_rows[i].want);
        end

        // Random segments, with one fill to capacity and one full drain in between.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % SEGMENT_LEN == 0) begin
                mix = $urandom_range(MIX_BALANCED, MIX_SHRINK);
            end
            if (i == N_RANDOM / 3) begin
                while (calc_count < STACK_DEPTH) send_random(rpn_pkg::CMD_PUSH);
                send_random(rpn_pkg::CMD_PUSH);
                send_random(rpn_pkg::CMD_PUSH);
                send_random(rpn_pkg::CMD_MUL);
            end
            if (i == N_RANDOM / 2) begin
                hold_off_req = 1'b1;
            end
            if (i == 2 * N_RANDOM / 3) begin
                while (calc_count > 0) send_random(rpn_pkg::CMD_POP);
                send_random(rpn_pkg::CMD_POP);
                send_random(rpn_pkg::CMD_SUB);
            end
            send_random(pick_command(mix));
        end

        // Invalid token halts the block; later words only report the halt.
        send_random(rpn_pkg::CMD_INVALID);
        send_random(rpn_pkg::CMD_PUSH);
        send_random(rpn_pkg::CMD_ADD);
        send_random(rpn_pkg::CMD_POP);
        send_random(CMD_UNUSED);
        send_random(rpn_pkg::CMD_DIV);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d tokens (%0d directed), checked %0d results, deepest stack %0d.",
                 words_sent, N_DIRECTED, results_seen, peak_depth);
        $display("Statuses: %0d ok, %0d overflow, %0d underflow, %0d divide by zero, %0d halted.",
                 status_hits[int'(rpn_pkg::ST_OK)],
                 status_hits[int'(rpn_pkg::ST_OVERFLOW)],
                 status_hits[int'(rpn_pkg::ST_UNDERFLOW)],
                 status_hits[int'(rpn_pkg::ST_DIVZERO)],
                 status_hits[int'(rpn_pkg::ST_HALTED)]);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
